// ===== hw/rtl/pis_pkg.sv =====
// pis_pkg: shared types and constants of the pyro igniter sequencer
// word formats, register map, sequencer phase codes and reset values
// no dependencies
package pis_pkg;

   // request word codes
   localparam logic [1:0] REQ_TICK   = 2'd0;
   localparam logic [1:0] REQ_FIRE   = 2'd1;
   localparam logic [1:0] REQ_MANUAL = 2'd2;
   localparam logic [1:0] REQ_QUERY  = 2'd3;

   // status answer codes
   localparam logic [1:0] STATUS_UNKNOWN = 2'd0;
   localparam logic [1:0] STATUS_READY   = 2'd1;
   localparam logic [1:0] STATUS_ACTIVE  = 2'd2;
   localparam logic [1:0] STATUS_OPEN    = 2'd3;

   // fire mode codes
   localparam logic [1:0] MODE_DUAL   = 2'd0;
   localparam logic [1:0] MODE_APOGEE = 2'd1;
   localparam logic [1:0] MODE_MAIN   = 2'd2;

   // register indexes
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRE_MODE       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_APOGEE_DELAY    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TICKS_PER_SEC   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRE_PULSE      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHARGE_GAP      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_OPEN_THRESHOLD  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLOSED_THRESHOLD = 3'd6;

   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned TIMER_W    = 24;

   // register reset values
   localparam logic [1:0]         RST_FIRE_MODE        = MODE_DUAL;
   localparam logic [7:0]         RST_APOGEE_DELAY     = 8'd0;
   localparam logic [9:0]         RST_TICKS_PER_SEC    = 10'd100;
   localparam logic [15:0]        RST_FIRE_PULSE       = 16'd5;
   localparam logic [15:0]        RST_CHARGE_GAP       = 16'd200;
   localparam logic signed [15:0] RST_OPEN_THRESHOLD   = 16'sd1000;
   localparam logic signed [15:0] RST_CLOSED_THRESHOLD = 16'sd7000;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_DELAY  = 3'd1,
      PH_PULSE1 = 3'd2,
      PH_GAP    = 3'd3,
      PH_PULSE2 = 3'd4,
      PH_CHARGE = 3'd5
   } phase_type;

   typedef struct packed {
      logic [1:0]         req_type;
      logic               channel;
      logic signed [15:0] sense_value;
   } req_word_type;

   typedef struct packed {
      logic       drogue_drive;
      logic       main_drive;
      logic [1:0] igniter_status;
      logic       busy_res;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0]         fire_mode;
      logic [7:0]         apogee_delay_seconds;
      logic [9:0]         ticks_per_second;
      logic [15:0]        fire_pulse_ticks;
      logic [15:0]        charge_gap_ticks;
      logic signed [15:0] open_threshold;
      logic signed [15:0] closed_threshold;
   } cfg_type;

   typedef struct packed {
      phase_type            phase;
      logic [TIMER_W-1:0]   timer;
      logic                 serving;
      logic                 manual_run;
      logic [1:0]           drive_pins;
      logic [1:0]           request_flags;
      logic [1:0]           fired_flags;
      logic [1:0]           firing_flags;
   } seq_state_type;

endpackage

// ===== hw/rtl/pyro_igniter_sequencer.sv =====
// pyro_igniter_sequencer: two-channel igniter fire sequencer with status queries
// one module; uses pis_pkg for word formats, register map and phase codes
//
// latency: the result word for a request word is registered at the accepting edge
//   and offered from the next cycle on
// throughput: one word per cycle unless stalled; all sequencer work for a word is a
//   single pass from state registers to result register, set by the tick/phase chain
// reset: synchronous, clears sequencer state and result valid, loads register defaults
module pyro_igniter_sequencer
   import pis_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_word_type           req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_word_type           rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type       cfg_ff, cfg_in;
   seq_state_type seq_ff, seq_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_word_type  rsp_data_ff, rsp_data_in;
   logic          req_accept;
   logic [17:0]   delay_ticks;

   function automatic logic [TIMER_W-1:0] at_least_one(input logic [15:0] v);
      return {8'd0, (v == 16'd0) ? 16'd1 : v};
   endfunction

   function automatic logic [1:0] pulse_count(input logic [1:0] mode, input logic ch);
      logic [1:0] n;
      case (mode)
         MODE_DUAL:   n = 2'd1;
         MODE_APOGEE: n = (ch == 1'b0) ? 2'd2 : 2'd0;
         MODE_MAIN:   n = (ch == 1'b1) ? 2'd2 : 2'd0;
         default:     n = 2'd0;
      endcase
      return n;
   endfunction

   function automatic seq_state_type end_pattern(input seq_state_type s, input cfg_type c);
      seq_state_type r;
      r = s;
      r.drive_pins = 2'b00;
      r.firing_flags[r.serving] = 1'b0;
      if (r.manual_run) begin
         r.manual_run = 1'b0;
         r.phase = PH_IDLE;
         r.timer = '0;
      end else begin
         r.phase = PH_CHARGE;
         r.timer = at_least_one(c.charge_gap_ticks);
      end
      return r;
   endfunction

   function automatic seq_state_type begin_pattern(input seq_state_type s, input cfg_type c);
      seq_state_type r;
      r = s;
      r.firing_flags[r.serving] = 1'b1;
      if (pulse_count(c.fire_mode, r.serving) == 2'd0) begin
         r = end_pattern(r, c);
      end else begin
         // dual mode drives the served channel's own pin, double modes start on drogue
         if (c.fire_mode == MODE_DUAL) begin
            r.drive_pins = r.serving ? 2'b10 : 2'b01;
         end else begin
            r.drive_pins = 2'b01;
         end
         r.phase = PH_PULSE1;
         r.timer = at_least_one(c.fire_pulse_ticks);
      end
      return r;
   endfunction

   function automatic seq_state_type phase_done(input seq_state_type s, input cfg_type c);
      seq_state_type r;
      r = s;
      case (r.phase)
         PH_DELAY: begin
            r = begin_pattern(r, c);
         end
         PH_PULSE1: begin
            r.drive_pins = 2'b00;
            if (pulse_count(c.fire_mode, r.serving) == 2'd2) begin
               r.phase = PH_GAP;
               r.timer = at_least_one(c.charge_gap_ticks);
            end else begin
               r = end_pattern(r, c);
            end
         end
         PH_GAP: begin
            r.phase = PH_PULSE2;
            r.drive_pins = 2'b10;
            r.timer = at_least_one(c.fire_pulse_ticks);
         end
         PH_PULSE2: begin
            r = end_pattern(r, c);
         end
         default: begin
            r.fired_flags[r.serving] = 1'b1;
            r.phase = PH_IDLE;
            r.timer = '0;
         end
      endcase
      return r;
   endfunction

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign delay_ticks = cfg_ff.apogee_delay_seconds * cfg_ff.ticks_per_second;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_FIRE_MODE:        cfg_in.fire_mode = csr_data[1:0];
            CSR_APOGEE_DELAY:     cfg_in.apogee_delay_seconds = csr_data[7:0];
            CSR_TICKS_PER_SEC:    cfg_in.ticks_per_second = csr_data[9:0];
            CSR_FIRE_PULSE:       cfg_in.fire_pulse_ticks = csr_data;
            CSR_CHARGE_GAP:       cfg_in.charge_gap_ticks = csr_data;
            CSR_OPEN_THRESHOLD:   cfg_in.open_threshold = $signed(csr_data);
            CSR_CLOSED_THRESHOLD: cfg_in.closed_threshold = $signed(csr_data);
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   // sequencer next state
   always_comb begin
      seq_state_type s;
      logic          pend;
      logic          pend_ch;
      s = seq_ff;
      pend = 1'b0;
      pend_ch = 1'b0;
      if (req_accept) begin
         case (req_data.req_type)
            REQ_TICK: begin
               if (s.phase != PH_IDLE) begin
                  if (s.timer != '0) begin
                     s.timer = s.timer - 1'b1;
                  end
                  if (s.timer == '0) begin
                     s = phase_done(s, cfg_ff);
                  end
               end
            end
            REQ_FIRE: begin
               s.request_flags[req_data.channel] = 1'b1;
            end
            REQ_MANUAL: begin
               if (s.phase == PH_IDLE) begin
                  s.serving = req_data.channel;
                  s.manual_run = 1'b1;
                  s = begin_pattern(s, cfg_ff);
               end
            end
            default: begin
               s = s;
            end
         endcase
         // serve the lowest pending channel once idle, drogue first
         if (s.phase == PH_IDLE) begin
            if (s.request_flags[0] && !s.fired_flags[0]) begin
               pend = 1'b1;
               pend_ch = 1'b0;
            end else if (s.request_flags[1] && !s.fired_flags[1]) begin
               pend = 1'b1;
               pend_ch = 1'b1;
            end
            if (pend) begin
               s.serving = pend_ch;
               s.manual_run = 1'b0;
               if (!pend_ch && cfg_ff.apogee_delay_seconds != 8'd0 &&
                   cfg_ff.ticks_per_second != 10'd0) begin
                  s.phase = PH_DELAY;
                  s.timer = {6'd0, delay_ticks};
               end else begin
                  s = begin_pattern(s, cfg_ff);
               end
            end
         end
      end
      seq_in = s;
   end

   // result word
   always_comb begin
      logic [1:0] status;
      logic       ch;
      ch = req_data.channel;
      status = STATUS_UNKNOWN;
      if (req_data.req_type == REQ_QUERY) begin
         if (seq_ff.firing_flags[ch] ||
             (seq_ff.request_flags[ch] && !seq_ff.fired_flags[ch])) begin
            status = STATUS_ACTIVE;
         end else if ($signed(req_data.sense_value) < $signed(cfg_ff.open_threshold)) begin
            status = STATUS_OPEN;
         end else if ($signed(req_data.sense_value) > $signed(cfg_ff.closed_threshold)) begin
            status = STATUS_READY;
         end else begin
            status = STATUS_UNKNOWN;
         end
      end
      rsp_data_in.drogue_drive   = seq_in.drive_pins[0];
      rsp_data_in.main_drive     = seq_in.drive_pins[1];
      rsp_data_in.igniter_status = status;
      rsp_data_in.busy_res       = (seq_in.phase != PH_IDLE);
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff & rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fire_mode            <= RST_FIRE_MODE;
         cfg_ff.apogee_delay_seconds <= RST_APOGEE_DELAY;
         cfg_ff.ticks_per_second     <= RST_TICKS_PER_SEC;
         cfg_ff.fire_pulse_ticks     <= RST_FIRE_PULSE;
         cfg_ff.charge_gap_ticks     <= RST_CHARGE_GAP;
         cfg_ff.open_threshold       <= RST_OPEN_THRESHOLD;
         cfg_ff.closed_threshold     <= RST_CLOSED_THRESHOLD;
         seq_ff.phase                <= PH_IDLE;
         seq_ff.timer                <= '0;
         seq_ff.serving              <= 1'b0;
         seq_ff.manual_run           <= 1'b0;
         seq_ff.drive_pins           <= 2'b00;
         seq_ff.request_flags        <= 2'b00;
         seq_ff.fired_flags          <= 2'b00;
         seq_ff.firing_flags         <= 2'b00;
         rsp_valid_ff                <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         seq_ff       <= seq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

`ifndef SYNTHESIS
   a_pins_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(seq_ff.drive_pins))
      else $error("both igniter pins driven");

   a_pins_in_pulse: assert property (@(posedge clock) disable iff (reset)
      (seq_ff.drive_pins != 2'b00) |-> (seq_ff.phase == PH_PULSE1 || seq_ff.phase == PH_PULSE2))
      else $error("igniter driven outside a pulse phase");

   a_manual_in_pattern: assert property (@(posedge clock) disable iff (reset)
      seq_ff.manual_run |->
         (seq_ff.phase == PH_PULSE1 || seq_ff.phase == PH_GAP || seq_ff.phase == PH_PULSE2))
      else $error("manual run flag outside a pulse pattern");

   a_idle_timer_clear: assert property (@(posedge clock) disable iff (reset)
      (seq_ff.phase == PH_IDLE) |-> (seq_ff.timer == '0))
      else $error("phase timer running while idle");

   a_accept_gives_word: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted word produced no result");
`endif

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// testbench for pyro_igniter_sequencer: directed table then random phases, every result
// word checked against the table or an in-bench predictor; depends on pis_pkg and rtl
module testbench;
   import pis_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int unsigned DIRECTED_ROWS = 25;
   localparam int unsigned DIRECTED_SPLIT = 13;
   localparam int unsigned NUM_PHASES = 14;
   localparam int unsigned PHASE_ITEMS = 127;
   localparam int unsigned EXTREME_PHASE = 4;
   localparam int unsigned QUIET_LIMIT = 2000;

   typedef struct {
      req_word_type word;
      bit           typed;
      rsp_word_type want;
   } stim_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_word_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_word_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   pyro_igniter_sequencer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // predictor state
   cfg_type            seq_cfg;
   logic [1:0]         armed;
   logic [1:0]         spent;
   logic [1:0]         burning;
   phase_type          seq_phase;
   logic [TIMER_W-1:0] countdown;
   logic               served_ch;
   logic               manual_mode;
   logic [1:0]         pin_levels;

   stim_type     req_words_q[$];
   rsp_word_type pin_status_q[$];
   stim_type     directed_tab[DIRECTED_ROWS];
   int unsigned  fail_count = 0;
   bit           quiet_mode = 1'b0;

   function automatic int unsigned pulses_for(logic ch);
      case (seq_cfg.fire_mode)
         MODE_DUAL:   return 1;
         MODE_APOGEE: return (ch == 1'b0) ? 2 : 0;
         MODE_MAIN:   return (ch == 1'b1) ? 2 : 0;
         default:     return 0;
      endcase
   endfunction

   // zero lengths count as one tick
   function automatic logic [TIMER_W-1:0] ticks_of(logic [15:0] v);
      return (v == 16'd0) ? TIMER_W'(1) : TIMER_W'(v);
   endfunction

   function automatic void finish_pattern();
      pin_levels = 2'b00;
      burning[served_ch] = 1'b0;
      if (manual_mode) begin
         manual_mode = 1'b0;
         seq_phase = PH_IDLE;
         countdown = '0;
      end else begin
         seq_phase = PH_CHARGE;
         countdown = ticks_of(seq_cfg.charge_gap_ticks);
      end
   endfunction

   function automatic void start_pattern();
      burning[served_ch] = 1'b1;
      if (pulses_for(served_ch) == 0) begin
         finish_pattern();
      end else begin
         pin_levels = (seq_cfg.fire_mode == MODE_DUAL) ? (2'b01 << served_ch) : 2'b01;
         seq_phase = PH_PULSE1;
         countdown = ticks_of(seq_cfg.fire_pulse_ticks);
      end
   endfunction

   function automatic void phase_expired();
      case (seq_phase)
         PH_DELAY: start_pattern();
         PH_PULSE1: begin
            pin_levels = 2'b00;
            if (pulses_for(served_ch) == 2) begin
               seq_phase = PH_GAP;
               countdown = ticks_of(seq_cfg.charge_gap_ticks);
            end else begin
               finish_pattern();
            end
         end
         PH_GAP: begin
            seq_phase = PH_PULSE2;
            pin_levels = 2'b10;
            countdown = ticks_of(seq_cfg.fire_pulse_ticks);
         end
         PH_PULSE2: finish_pattern();
         default: begin
            spent[served_ch] = 1'b1;
            seq_phase = PH_IDLE;
            countdown = '0;
         end
      endcase
   endfunction

   // drogue first, then main
   function automatic void serve_pending();
      if (seq_phase == PH_IDLE) begin
         if (armed[0] && !spent[0]) begin
            served_ch = 1'b0;
            manual_mode = 1'b0;
            if (seq_cfg.apogee_delay_seconds != 0 && seq_cfg.ticks_per_second != 0) begin
               seq_phase = PH_DELAY;
               countdown = TIMER_W'(seq_cfg.apogee_delay_seconds)
                         * TIMER_W'(seq_cfg.ticks_per_second);
            end else begin
               start_pattern();
            end
         end else if (armed[1] && !spent[1]) begin
            served_ch = 1'b1;
            manual_mode = 1'b0;
            start_pattern();
         end
      end
   endfunction

   function automatic rsp_word_type advance_sequencer(req_word_type w);
      rsp_word_type r;
      logic [1:0]   status;
      status = STATUS_UNKNOWN;
      case (w.req_type)
         REQ_TICK: begin
            if (seq_phase != PH_IDLE) begin
               if (countdown > 0) countdown = countdown - 1'b1;
               if (countdown == 0) phase_expired();
            end
         end
         REQ_FIRE: armed[w.channel] = 1'b1;
         REQ_MANUAL: begin
            if (seq_phase == PH_IDLE) begin
               served_ch = w.channel;
               manual_mode = 1'b1;
               start_pattern();
            end
         end
         default: begin
            if (burning[w.channel] || (armed[w.channel] && !spent[w.channel]))
               status = STATUS_ACTIVE;
            else if ($signed(w.sense_value) < $signed(seq_cfg.open_threshold))
               status = STATUS_OPEN;
            else if ($signed(w.sense_value) > $signed(seq_cfg.closed_threshold))
               status = STATUS_READY;
            else
               status = STATUS_UNKNOWN;
         end
      endcase
      serve_pending();
      r.drogue_drive = pin_levels[0];
      r.main_drive = pin_levels[1];
      r.igniter_status = status;
      r.busy_res = (seq_phase != PH_IDLE);
      return r;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(30, 80);
   endfunction

   function automatic stim_type row(logic [1:0] kind, logic ch, int sense, bit typed,
                                    rsp_word_type want);
      stim_type s;
      s.word.req_type = kind;
      s.word.channel = ch;
      s.word.sense_value = 16'(sense);
      s.typed = typed;
      s.want = want;
      return s;
   endfunction

   function automatic rsp_word_type idle_rsp(logic [1:0] status);
      rsp_word_type r;
      r = '0;
      r.igniter_status = status;
      return r;
   endfunction

   function automatic cfg_type pick_cfg(bit extreme);
      cfg_type     c;
      int unsigned r;
      if (extreme) begin
         c.fire_mode = MODE_UNUSED;
         c.apogee_delay_seconds = 8'd255;
         c.ticks_per_second = 10'd1023;
         c.fire_pulse_ticks = 16'hFFFF;
         c.charge_gap_ticks = 16'hFFFF;
      end else begin
         c.fire_mode = 2'($urandom_range(0, 3));
         c.apogee_delay_seconds = 8'($urandom_range(0, 3));
         c.ticks_per_second = 10'($urandom_range(0, 3));
         c.fire_pulse_ticks = 16'($urandom_range(0, 4));
         c.charge_gap_ticks = 16'($urandom_range(0, 6));
      end
      r = $urandom_range(0, 3);
      case (r)
         0: begin
            c.open_threshold = 16'($urandom);
            c.closed_threshold = 16'($urandom);
         end
         1: begin
            c.open_threshold = 16'($urandom_range(0, 4000)) - 16'd2000;
            c.closed_threshold = c.open_threshold + 16'($urandom_range(0, 8000));
         end
         2: begin
            c.open_threshold = 16'h8000;
            c.closed_threshold = 16'h7FFF;
         end
         default: begin
            c.open_threshold = 16'h7FFF;
            c.closed_threshold = 16'h8000;
         end
      endcase
      return c;
   endfunction

   // hold_timers: only queries and fire requests, so no tick counts a timer down
   function automatic req_word_type random_item(bit hold_timers);
      req_word_type w;
      int unsigned  r;
      w.channel = 1'($urandom_range(0, 1));
      w.sense_value = 16'($urandom);
      r = $urandom_range(0, 99);
      if (hold_timers) w.req_type = (r < 80) ? REQ_QUERY : REQ_FIRE;
      else if (r < 50) w.req_type = REQ_TICK;
      else if (r < 62) w.req_type = REQ_MANUAL;
      else if (r < 67) w.req_type = REQ_FIRE;
      else w.req_type = REQ_QUERY;
      if (w.req_type == REQ_QUERY) begin
         r = $urandom_range(0, 2);
         // samples at or next to a threshold
         if (r == 1)
            w.sense_value = seq_cfg.open_threshold + 16'($urandom_range(0, 2)) - 16'd1;
         else if (r == 2)
            w.sense_value = seq_cfg.closed_threshold + 16'($urandom_range(0, 2)) - 16'd1;
      end
      return w;
   endfunction

   initial begin
      seq_cfg.fire_mode = RST_FIRE_MODE;
      seq_cfg.apogee_delay_seconds = RST_APOGEE_DELAY;
      seq_cfg.ticks_per_second = RST_TICKS_PER_SEC;
      seq_cfg.fire_pulse_ticks = RST_FIRE_PULSE;
      seq_cfg.charge_gap_ticks = RST_CHARGE_GAP;
      seq_cfg.open_threshold = RST_OPEN_THRESHOLD;
      seq_cfg.closed_threshold = RST_CLOSED_THRESHOLD;
      armed = '0;
      spent = '0;
      burning = '0;
      seq_phase = PH_IDLE;
      countdown = '0;
      served_ch = 1'b0;
      manual_mode = 1'b0;
      pin_levels = 2'b00;
   end

   // request side: offer words, predict each accepted word
   always @(posedge clock) begin : req_driver
      static stim_type    offered;
      static int unsigned gap_left = 0;
      rsp_word_type       predicted;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predicted = advance_sequencer(offered.word);
            pin_status_q.push_back(offered.typed ? offered.want : predicted);
         end
         if (!(req_valid && req_stall)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (req_words_q.size() > 0) begin
               offered = req_words_q.pop_front();
               req_valid <= 1'b1;
               req_data <= offered.word;
               gap_left = quiet_mode ? 0 : idle_len();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   // result side: random stall, compare accepted words
   always @(posedge clock) begin : rsp_monitor
      static int unsigned free_left = 0;
      static int unsigned stall_left = 0;
      rsp_word_type       want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pin_status_q.size() == 0) begin
            $error("rsp word with no prediction waiting");
            fail_count++;
         end else begin
            want = pin_status_q.pop_front();
            check_field("drogue_drive", want.drogue_drive, rsp_data.drogue_drive);
            check_field("main_drive", want.main_drive, rsp_data.main_drive);
            check_field("igniter_status", want.igniter_status, rsp_data.igniter_status);
            check_field("busy_res", want.busy_res, rsp_data.busy_res);
         end
      end
      if (free_left == 0 && stall_left == 0) begin
         free_left = $urandom_range(1, 12);
         stall_left = quiet_mode ? 0 : idle_len();
      end
      if (free_left > 0) begin
         free_left--;
         rsp_stall <= 1'b0;
      end else begin
         stall_left--;
         rsp_stall <= 1'b1;
      end
   end

   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
             || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("pyro_igniter_sequencer test failed");
      $finish;
   end

   // wait until every word is offered and every result is back
   task automatic drain();
      while (req_words_q.size() != 0 || req_valid || pin_status_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_config(cfg_type c);
      logic [CSR_INDEX_W-1:0] order[7];
      logic [CSR_DATA_W-1:0]  val;
      order = '{CSR_FIRE_MODE, CSR_APOGEE_DELAY, CSR_TICKS_PER_SEC, CSR_FIRE_PULSE,
                CSR_CHARGE_GAP, CSR_OPEN_THRESHOLD, CSR_CLOSED_THRESHOLD};
      csr_valid <= 1'b1;
      foreach (order[i]) begin
         case (order[i])
            CSR_FIRE_MODE:      val = CSR_DATA_W'(c.fire_mode);
            CSR_APOGEE_DELAY:   val = CSR_DATA_W'(c.apogee_delay_seconds);
            CSR_TICKS_PER_SEC:  val = CSR_DATA_W'(c.ticks_per_second);
            CSR_FIRE_PULSE:     val = c.fire_pulse_ticks;
            CSR_CHARGE_GAP:     val = c.charge_gap_ticks;
            CSR_OPEN_THRESHOLD: val = c.open_threshold;
            default:            val = c.closed_threshold;
         endcase
         csr_index <= order[i];
         csr_data <= val;
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      seq_cfg = c;
   endtask

   initial begin : main
      cfg_type  phase_cfg;
      stim_type s;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      directed_tab = '{
         // reset settings: idle answers at the sense extremes and thresholds
         row(REQ_TICK,   1'b0,      0, 1'b1, idle_rsp(STATUS_UNKNOWN)),
         row(REQ_QUERY,  1'b0, -32768, 1'b1, idle_rsp(STATUS_OPEN)),
         row(REQ_QUERY,  1'b1,  32767, 1'b1, idle_rsp(STATUS_READY)),
         row(REQ_QUERY,  1'b0,   1000, 1'b1, idle_rsp(STATUS_UNKNOWN)),
         row(REQ_QUERY,  1'b1,    999, 1'b1, idle_rsp(STATUS_OPEN)),
         row(REQ_MANUAL, 1'b1,     -1, 1'b0, '0),
         row(REQ_QUERY,  1'b1,   7001, 1'b0, '0),
         // manual fire while busy is dropped
         row(REQ_MANUAL, 1'b0,      0, 1'b0, '0),
         row(REQ_TICK,   1'b1,      0, 1'b0, '0),
         row(REQ_TICK,   1'b0,      0, 1'b0, '0),
         row(REQ_TICK,   1'b1,      0, 1'b0, '0),
         row(REQ_TICK,   1'b0,      0, 1'b0, '0),
         row(REQ_TICK,   1'b1,      0, 1'b0, '0),
         // apogee mode with delay: drogue gets both pulses, main gets none
         row(REQ_FIRE,   1'b0,      0, 1'b0, '0),
         row(REQ_QUERY,  1'b0,  32767, 1'b0, '0),
         row(REQ_FIRE,   1'b1,      0, 1'b0, '0),
         row(REQ_QUERY,  1'b1, -32768, 1'b0, '0),
         row(REQ_TICK,   1'b0,      0, 1'b0, '0),
         row(REQ_TICK,   1'b0,      0, 1'b0, '0),
         row(REQ_TICK,   1'b0,      0, 1'b0, '0),
         row(REQ_TICK,   1'b0,      0, 1'b0, '0),
         row(REQ_TICK,   1'b0,      0, 1'b0, '0),
         row(REQ_TICK,   1'b0,      0, 1'b0, '0),
         row(REQ_TICK,   1'b0,      0, 1'b0, '0),
         row(REQ_QUERY,  1'b0, -32768, 1'b1, idle_rsp(STATUS_UNKNOWN))
      };

      phase_cfg.fire_mode = MODE_APOGEE;
      phase_cfg.apogee_delay_seconds = 8'd1;
      phase_cfg.ticks_per_second = 10'd2;
      phase_cfg.fire_pulse_ticks = 16'd1;
      phase_cfg.charge_gap_ticks = 16'd1;
      phase_cfg.open_threshold = 16'h8000;
      phase_cfg.closed_threshold = 16'h7FFF;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (i == DIRECTED_SPLIT) begin
            drain();
            write_config(phase_cfg);
         end
         req_words_q.push_back(directed_tab[i]);
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         drain();
         phase_cfg = pick_cfg(p == EXTREME_PHASE);
         write_config(phase_cfg);
         quiet_mode = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            s.word = random_item(p == EXTREME_PHASE);
            s.typed = 1'b0;
            s.want = '0;
            req_words_q.push_back(s);
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (pin_status_q.size() != 0) begin
         $error("%0d predicted words never arrived", pin_status_q.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("pyro_igniter_sequencer test passed");
      else
         $display("pyro_igniter_sequencer test failed");
      $finish;
   end

endmodule
